// ===== hdl/pog_pkg.sv =====
package pog_pkg;

  localparam int MAX_DIMENSIONS_DEF = 3;
  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  localparam logic [30:0] OUTLET_RESET = 31'd65536;
  localparam logic [1:0] DIMS_RESET = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_OUTLET = 1'b0;
  localparam logic REG_DIMS = 1'b1;

  // floor(x / 5) == (x * DIV5_RECIP) >> 34 for any 32-bit x
  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam logic [33:0] E_MAX = 34'h0_7FFF_FFFF;

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0][31:0] n;
    logic [2:0] used;
    logic [30:0] rho_in;
    logic [30:0] rho;
    logic [31:0] e;
    logic side;
  } item_t;

  typedef struct packed {
    logic [31:0] ghost_momentum_x;
    logic [31:0] ghost_momentum_y;
    logic [31:0] ghost_momentum_z;
    logic [30:0] ghost_density;
    logic [31:0] ghost_total_energy;
    logic subsonic;
  } result_t;

endpackage

// ===== hdl/pressure_outflow_ghost_state.sv =====
// Subsonic pressure outflow ghost state, one boundary quadrature point per beat.
// Input channel: push/full queue; a beat carries momentum, density, energy,
// face normal and interior side. Result channel: empty/pop queue; the head
// result sits on the ghost_* and subsonic ports while empty is low.
// Config: APB write of outlet_pressure at 0x0 and dimensions at 0x4; write
// only while no beat is in flight.
// Throughput: one beat per cycle while the result queue has room, with no
// dependency between beats. Path: front register, input queue, registers
// b1-b3, then bit-per-stage units: KE divider (32), registers p1-p3,
// pressure-over-density divider (47), two square roots (32 each), normal
// velocity dividers (33 and 32), result register and result queue.
// Reset clears both queues and every stage valid; registers go to outlet
// pressure 1.0 and three dimensions. When pop stays low the result queue
// fills, the whole datapath holds and full rises once the front queue backs up;
// nothing is dropped.
module pressure_outflow_ghost_state #(
  parameter int MAX_DIMENSIONS = pog_pkg::MAX_DIMENSIONS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [31:0] momentum_x,
  input  logic [31:0] momentum_y,
  input  logic [31:0] momentum_z,
  input  logic [30:0] density,
  input  logic [31:0] energy,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  input  logic interior_side,
  output logic empty,
  input  logic pop,
  output logic [31:0] ghost_momentum_x,
  output logic [31:0] ghost_momentum_y,
  output logic [31:0] ghost_momentum_z,
  output logic [30:0] ghost_density,
  output logic [31:0] ghost_total_energy,
  output logic subsonic,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [30:0] outlet_pressure;
  logic [1:0] dimensions;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_pressure <= pog_pkg::OUTLET_RESET;
      dimensions <= pog_pkg::DIMS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        pog_pkg::REG_OUTLET: outlet_pressure <= pwdata[30:0];
        pog_pkg::REG_DIMS: dimensions <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pog_pkg::REG_OUTLET: prdata = {1'b0, outlet_pressure};
      pog_pkg::REG_DIMS: prdata = {30'd0, dimensions};
      default: prdata = '0;
    endcase
  end

  logic iq_full, iq_push, iq_empty, iq_pop;
  pog_pkg::item_t iq_in, iq_out;
  logic oq_full, oq_push;
  pog_pkg::result_t oq_in, oq_out;

  pog_front #(.MAX_DIMENSIONS(MAX_DIMENSIONS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .m_in({momentum_z, momentum_y, momentum_x}),
    .n_in({normal_z, normal_y, normal_x}),
    .rho_in(density), .e_in(energy), .side_in(interior_side),
    .dimensions(dimensions),
    .iq_full(iq_full), .iq_push(iq_push), .iq_item(iq_in)
  );

  pog_fifo #(.WIDTH($bits(pog_pkg::item_t)), .DEPTH(pog_pkg::IQ_DEPTH)) u_iq (
    .clk(clk), .rst(rst), .push(iq_push), .din(iq_in), .full(iq_full),
    .pop(iq_pop), .dout(iq_out), .empty(iq_empty)
  );

  pog_back u_back (
    .clk(clk), .rst(rst), .iq_empty(iq_empty), .iq_item(iq_out), .iq_pop(iq_pop),
    .outlet_pressure(outlet_pressure),
    .oq_full(oq_full), .oq_push(oq_push), .res(oq_in)
  );

  pog_fifo #(.WIDTH($bits(pog_pkg::result_t)), .DEPTH(pog_pkg::OQ_DEPTH)) u_oq (
    .clk(clk), .rst(rst), .push(oq_push), .din(oq_in), .full(oq_full),
    .pop(pop), .dout(oq_out), .empty(empty)
  );

  assign ghost_momentum_x = oq_out.ghost_momentum_x;
  assign ghost_momentum_y = oq_out.ghost_momentum_y;
  assign ghost_momentum_z = oq_out.ghost_momentum_z;
  assign ghost_density = oq_out.ghost_density;
  assign ghost_total_energy = oq_out.ghost_total_energy;
  assign subsonic = oq_out.subsonic;
endmodule

// ===== hdl/pog_fifo.sv =====
module pog_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] din,
  output logic full,
  input  logic pop,
  output logic [WIDTH-1:0] dout,
  output logic empty
);
  // DEPTH is a power of two so the pointers wrap on their own
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/pog_div.sv =====
// Restoring divider, one quotient bit per stage. The caller guarantees
// rem_in < divisor, so the quotient fits in Q bits.
module pog_div #(
  parameter int W = 32,
  parameter int Q = 32,
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [W-1:0] rem_in,
  input  logic [Q-1:0] low_in,
  input  logic [W-1:0] divisor,
  input  logic [TAG_W-1:0] tag_in,
  output logic out_valid,
  output logic [Q-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);
  logic [W-1:0] rem_q [Q];
  logic [Q-1:0] sh_q [Q];
  logic [W-1:0] dv_q [Q];
  logic [TAG_W-1:0] tag_q [Q];
  logic vld_q [Q];

  for (genvar s = 0; s < Q; s++) begin : g_st
    logic [W-1:0] r_i;
    logic [Q-1:0] sh_i;
    logic [W-1:0] d_i;
    logic [TAG_W-1:0] t_i;
    logic v_i;
    logic [W:0] trial;
    logic ge;

    if (s == 0) begin : g_first
      assign r_i = rem_in;
      assign sh_i = low_in;
      assign d_i = divisor;
      assign t_i = tag_in;
      assign v_i = in_valid;
    end else begin : g_next
      assign r_i = rem_q[s-1];
      assign sh_i = sh_q[s-1];
      assign d_i = dv_q[s-1];
      assign t_i = tag_q[s-1];
      assign v_i = vld_q[s-1];
    end

    assign trial = {r_i, sh_i[Q-1]};
    assign ge = (trial >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? W'(trial - {1'b0, d_i}) : trial[W-1:0];
        sh_q[s] <= {sh_i[Q-2:0], ge};
        dv_q[s] <= d_i;
        tag_q[s] <= t_i;
      end
    end
  end

  assign out_valid = vld_q[Q-1];
  assign quot = sh_q[Q-1];
  assign tag_out = tag_q[Q-1];
endmodule

// ===== hdl/pog_sqrt.sv =====
// Floor square root, one result bit (two radicand bits) per stage.
module pog_sqrt #(
  parameter int N = 32,
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2*N-1:0] rad_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic out_valid,
  output logic [N-1:0] root,
  output logic [TAG_W-1:0] tag_out
);
  localparam int RW = N + 1;
  localparam int TW = N + 3;

  logic [RW-1:0] rem_q [N];
  logic [N-1:0] root_q [N];
  logic [2*N-1:0] rad_q [N];
  logic [TAG_W-1:0] tag_q [N];
  logic vld_q [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [RW-1:0] r_i;
    logic [N-1:0] rt_i;
    logic [2*N-1:0] rd_i;
    logic [TAG_W-1:0] t_i;
    logic v_i;
    logic [TW-1:0] trial;
    logic [TW-1:0] cand;
    logic ge;

    if (s == 0) begin : g_first
      assign r_i = '0;
      assign rt_i = '0;
      assign rd_i = rad_in;
      assign t_i = tag_in;
      assign v_i = in_valid;
    end else begin : g_next
      assign r_i = rem_q[s-1];
      assign rt_i = root_q[s-1];
      assign rd_i = rad_q[s-1];
      assign t_i = tag_q[s-1];
      assign v_i = vld_q[s-1];
    end

    assign trial = {r_i, rd_i[2*N-1:2*N-2]};
    assign cand = {1'b0, rt_i, 2'b01};
    assign ge = (trial >= cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? RW'(trial - cand) : RW'(trial);
        root_q[s] <= {rt_i[N-2:0], ge};
        rad_q[s] <= {rd_i[2*N-3:0], 2'b00};
        tag_q[s] <= t_i;
      end
    end
  end

  assign out_valid = vld_q[N-1];
  assign root = root_q[N-1];
  assign tag_out = tag_q[N-1];
endmodule

// ===== hdl/pog_front.sv =====
module pog_front #(
  parameter int MAX_DIMENSIONS = pog_pkg::MAX_DIMENSIONS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0][31:0] m_in,
  input  logic [2:0][31:0] n_in,
  input  logic [30:0] rho_in,
  input  logic [31:0] e_in,
  input  logic side_in,
  input  logic [1:0] dimensions,
  input  logic iq_full,
  output logic iq_push,
  output pog_pkg::item_t iq_item
);
  logic f_valid;
  pog_pkg::item_t f_item;
  pog_pkg::item_t cls;
  logic [1:0] cnt;
  logic accept;

  assign full = f_valid && iq_full;
  assign accept = push && !full;
  assign iq_push = f_valid && !iq_full;
  assign iq_item = f_item;

  always_comb begin
    cnt = (dimensions < 2'(MAX_DIMENSIONS)) ? dimensions : 2'(MAX_DIMENSIONS);
    cls.m = m_in;
    cls.n = n_in;
    for (int i = 0; i < 3; i++) begin
      cls.used[i] = (2'(i) < cnt);
    end
    cls.rho_in = rho_in;
    // zero density computes as one LSB
    cls.rho = (rho_in == '0) ? 31'd1 : rho_in;
    cls.e = e_in;
    cls.side = side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (iq_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= cls;
    end
  end
endmodule

// ===== hdl/pog_back.sv =====
module pog_back (
  input  logic clk,
  input  logic rst,
  input  logic iq_empty,
  input  pog_pkg::item_t iq_item,
  output logic iq_pop,
  input  logic [30:0] outlet_pressure,
  input  logic oq_full,
  output logic oq_push,
  output pog_pkg::result_t res
);
  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [30:0] rho_in;
    logic [31:0] e;
  } keep_t;

  typedef struct packed {
    logic [63:0] nn;
    logic [63:0] dmag;
    logic neg;
    logic ke_big;
    logic [30:0] rho;
    keep_t keep;
  } tag_a_t;

  typedef struct packed {
    logic [63:0] nn;
    logic [63:0] dmag;
    logic neg;
    logic [31:0] ke;
    logic ke_big;
    logic [30:0] rho;
    keep_t keep;
  } mid_t;

  typedef struct packed {
    logic [31:0] c;
    logic nz;
    logic [63:0] dmag;
    logic neg;
    logic [31:0] ke;
    logic ke_big;
    logic [30:0] rho;
    keep_t keep;
  } tail_t;

  typedef struct packed {
    logic [31:0] c;
    logic nz;
    logic neg;
    logic [31:0] ke;
    logic ke_big;
    logic [30:0] rho;
    keep_t keep;
  } tail2_t;

  typedef struct packed {
    logic vbig;
    tail2_t t;
  } tag_e_t;

  logic adv;
  logic f_valid;

  assign adv = !(f_valid && oq_full);
  assign oq_push = f_valid && !oq_full;
  assign iq_pop = adv && !iq_empty;

  // squares and cross products, three multipliers per lane
  logic [2:0][63:0] sqm_c, sqn_c, pr_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqm_c[i] = iq_item.used[i] ?
        64'($signed(iq_item.m[i]) * $signed(iq_item.m[i])) : '0;
      sqn_c[i] = iq_item.used[i] ?
        64'($signed(iq_item.n[i]) * $signed(iq_item.n[i])) : '0;
      pr_c[i] = iq_item.used[i] ?
        64'($signed(iq_item.m[i]) * $signed(iq_item.n[i])) : '0;
    end
  end

  keep_t keep_c;
  assign keep_c = '{mx: iq_item.m[0], my: iq_item.m[1], mz: iq_item.m[2],
                    rho_in: iq_item.rho_in, e: iq_item.e};

  logic b1_valid;
  logic [2:0][63:0] b1_sqm, b1_sqn, b1_pr;
  logic [30:0] b1_rho;
  logic b1_side;
  keep_t b1_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (adv) begin
      b1_valid <= !iq_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sqm <= sqm_c;
      b1_sqn <= sqn_c;
      b1_pr <= pr_c;
      b1_rho <= iq_item.rho;
      b1_side <= iq_item.side;
      b1_keep <= keep_c;
    end
  end

  // sums, with the dot product split by sign
  logic [63:0] dpos_c, dneg_c;
  always_comb begin
    dpos_c = '0;
    dneg_c = '0;
    for (int i = 0; i < 3; i++) begin
      if (b1_pr[i][63]) begin
        dneg_c = dneg_c + (64'd0 - b1_pr[i]);
      end else begin
        dpos_c = dpos_c + b1_pr[i];
      end
    end
  end

  logic b2_valid;
  logic [63:0] b2_mm, b2_nn, b2_dpos, b2_dneg;
  logic [30:0] b2_rho;
  logic b2_side;
  keep_t b2_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (adv) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_mm <= b1_sqm[0] + b1_sqm[1] + b1_sqm[2];
      b2_nn <= b1_sqn[0] + b1_sqn[1] + b1_sqn[2];
      b2_dpos <= dpos_c;
      b2_dneg <= dneg_c;
      b2_rho <= b1_rho;
      b2_side <= b1_side;
      b2_keep <= b1_keep;
    end
  end

  logic b3_valid;
  logic [63:0] b3_mm;
  tag_a_t b3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else if (adv) begin
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_mm <= b2_mm;
      b3_tag.nn <= b2_nn;
      b3_tag.dmag <= (b2_dpos >= b2_dneg) ? b2_dpos - b2_dneg : b2_dneg - b2_dpos;
      b3_tag.neg <= (b2_dpos < b2_dneg) ^ !b2_side;
      // KE of 2^32 or more forces pressure to zero and saturates the replaced energy
      b3_tag.ke_big <= (b2_mm[63:32] >= {b2_rho, 1'b0});
      b3_tag.rho <= b2_rho;
      b3_tag.keep <= b2_keep;
    end
  end

  // KE = mm / (2 rho)
  logic ka_valid;
  logic [31:0] ka_ke;
  tag_a_t ka_tag;

  pog_div #(.W(32), .Q(32), .TAG_W($bits(tag_a_t))) u_ke_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(b3_valid),
    .rem_in(b3_tag.ke_big ? 32'd0 : b3_mm[63:32]),
    .low_in(b3_mm[31:0]),
    .divisor({b3_tag.rho, 1'b0}),
    .tag_in(b3_tag),
    .out_valid(ka_valid), .quot(ka_ke), .tag_out(ka_tag)
  );

  mid_t ka_mid;
  assign ka_mid = '{nn: ka_tag.nn, dmag: ka_tag.dmag, neg: ka_tag.neg, ke: ka_ke,
                    ke_big: ka_tag.ke_big, rho: ka_tag.rho, keep: ka_tag.keep};

  logic [32:0] diff_c;
  logic pos_c;
  assign diff_c = {ka_tag.keep.e[31], ka_tag.keep.e} - {1'b0, ka_ke};
  assign pos_c = !ka_tag.ke_big &&
                 ($signed({ka_tag.keep.e[31], ka_tag.keep.e}) > $signed({1'b0, ka_ke}));

  logic p1_valid, p2_valid, p3_valid;
  mid_t p1_mid, p2_mid, p3_mid;
  logic [31:0] p1_twodiff;
  logic [63:0] p2_prod;
  logic [29:0] p_c;
  logic [32:0] p3_sevp;
  logic [33:0] p3_div5;

  assign p_c = p2_prod[63:34];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= ka_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mid <= ka_mid;
      p1_twodiff <= pos_c ? {diff_c[30:0], 1'b0} : 32'd0;
      p2_mid <= p1_mid;
      p2_prod <= 64'(p1_twodiff) * 64'(pog_pkg::DIV5_RECIP);
      p3_mid <= p2_mid;
      p3_sevp <= 33'({p_c, 3'b000}) - 33'(p_c);
      p3_div5 <= 34'({p2_mid.rho, 2'b00}) + 34'(p2_mid.rho);
    end
  end

  // (7p << 16) / (5 rho)
  logic qd_valid;
  logic [46:0] qd_q;
  mid_t qd_mid;

  pog_div #(.W(34), .Q(47), .TAG_W($bits(mid_t))) u_q_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(p3_valid),
    .rem_in(34'(p3_sevp[32:31])),
    .low_in({p3_sevp[30:0], 16'h0000}),
    .divisor(p3_div5),
    .tag_in(p3_mid),
    .out_valid(qd_valid), .quot(qd_q), .tag_out(qd_mid)
  );

  // sound speed
  logic cs_valid;
  logic [31:0] cs_c;
  mid_t cs_mid;

  pog_sqrt #(.N(32), .TAG_W($bits(mid_t))) u_c_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(qd_valid),
    .rad_in({1'b0, qd_q, 16'h0000}),
    .tag_in(qd_mid),
    .out_valid(cs_valid), .root(cs_c), .tag_out(cs_mid)
  );

  tail_t cs_tail;
  assign cs_tail = '{c: cs_c, nz: |cs_mid.nn, dmag: cs_mid.dmag, neg: cs_mid.neg,
                     ke: cs_mid.ke, ke_big: cs_mid.ke_big, rho: cs_mid.rho,
                     keep: cs_mid.keep};

  // normal length
  logic ls_valid;
  logic [31:0] ls_len;
  tail_t ls_tail;

  pog_sqrt #(.N(32), .TAG_W($bits(tail_t))) u_len_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(cs_valid),
    .rad_in(cs_mid.nn),
    .tag_in(cs_tail),
    .out_valid(ls_valid), .root(ls_len), .tag_out(ls_tail)
  );

  tail2_t ls_t2;
  assign ls_t2 = '{c: ls_tail.c, nz: ls_tail.nz, neg: ls_tail.neg, ke: ls_tail.ke,
                   ke_big: ls_tail.ke_big, rho: ls_tail.rho, keep: ls_tail.keep};

  // w = |m.n| / |n|, below 2^33 whenever the normal is nonzero
  logic wd_valid;
  logic [32:0] wd_w;
  tail2_t wd_t2;

  pog_div #(.W(32), .Q(33), .TAG_W($bits(tail2_t))) u_w_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(ls_valid),
    .rem_in(32'(ls_tail.dmag[63:33])),
    .low_in(ls_tail.dmag[32:0]),
    .divisor(ls_len),
    .tag_in(ls_t2),
    .out_valid(wd_valid), .quot(wd_w), .tag_out(wd_t2)
  );

  tag_e_t wd_tag;
  assign wd_tag.vbig = (31'(wd_w[32:16]) >= wd_t2.rho);
  assign wd_tag.t = wd_t2;

  // vn = (w << 16) / rho, saturation flagged by vbig
  logic vd_valid;
  logic [31:0] vd_vn;
  tag_e_t vd_tag;

  pog_div #(.W(31), .Q(32), .TAG_W($bits(tag_e_t))) u_vn_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(wd_valid),
    .rem_in(wd_tag.vbig ? 31'd0 : 31'(wd_w[32:16])),
    .low_in({wd_w[15:0], 16'h0000}),
    .divisor(wd_t2.rho),
    .tag_in(wd_tag),
    .out_valid(vd_valid), .quot(vd_vn), .tag_out(vd_tag)
  );

  logic [33:0] op5;
  logic [32:0] half5;
  assign op5 = 34'({outlet_pressure, 2'b00}) + 34'(outlet_pressure);

  always_ff @(posedge clk) begin
    half5 <= op5[33:1];
  end

  logic vzero, vlt, sub;
  logic [33:0] gsum;
  logic gsat;
  tail2_t vt;

  assign vt = vd_tag.t;
  assign vzero = !vt.nz || (!vd_tag.vbig && vd_vn == '0);
  assign vlt = !vt.nz ? (vt.c != '0) : (!vd_tag.vbig && vd_vn < vt.c);
  assign sub = (vt.neg && !vzero) || vlt;
  assign gsum = 34'(half5) + 34'(vt.ke);
  assign gsat = vt.ke_big || (gsum > pog_pkg::E_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= vd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.ghost_momentum_x <= vt.keep.mx;
      res.ghost_momentum_y <= vt.keep.my;
      res.ghost_momentum_z <= vt.keep.mz;
      res.ghost_density <= vt.keep.rho_in;
      res.subsonic <= sub;
      if (!sub) begin
        res.ghost_total_energy <= vt.keep.e;
      end else if (gsat) begin
        res.ghost_total_energy <= pog_pkg::E_MAX[31:0];
      end else begin
        res.ghost_total_energy <= gsum[31:0];
      end
    end
  end
endmodule

// ===== hdl/pog_checker.sv =====
module pog_checker (
  input logic clk,
  input logic rst,
  input logic pop,
  input logic empty,
  input logic [31:0] ghost_total_energy,
  input logic subsonic,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic [2:0] paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  // nothing can come out right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result present right after reset");

  // replaced energy is a saturated nonnegative sum
  a_sub_nonneg: assert property (@(posedge clk) disable iff (rst)
    (!empty && subsonic) |-> !ghost_total_energy[31])
    else $error("negative ghost energy on a subsonic point");

  a_outlet_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == pog_pkg::REG_OUTLET)
      ##1 (paddr[2] == pog_pkg::REG_OUTLET)
      |-> prdata == {1'b0, $past(pwdata[30:0])})
    else $error("outlet pressure readback mismatch");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(ghost_total_energy) && $stable(subsonic)))
    else $error("stalled result changed");
endmodule

bind pressure_outflow_ghost_state pog_checker u_pog_checker (.*);
